@@ src/psl_pkg.sv @@
package psl_pkg;

  // Default number of list entries.
  localparam int CAPACITY = 16;

  // Fixed field widths.
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GET     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REPLACE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADVAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // Value returned when no entry is read.
  localparam logic [DATA_W-1:0] NO_VALUE = 32'hFFFF_FFFF;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } psl_cmd_t;

endpackage

@@ src/psl_if.sv @@
// Request channel: one list operation per item.
interface psl_req_if;
  logic                               valid;
  logic                               ready;
  logic [psl_pkg::FUNC_W-1:0]         func;
  logic [psl_pkg::POS_W-1:0]          position;
  logic signed [psl_pkg::DATA_W-1:0]  value_in;

  modport source (output valid, func, position, value_in, input ready);
  modport sink   (input valid, func, position, value_in, output ready);
endinterface

// Response channel: one result per operation.
interface psl_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [psl_pkg::STATUS_W-1:0]       status;
  logic signed [psl_pkg::DATA_W-1:0]  value_out;
  logic [psl_pkg::COUNT_W-1:0]        count;
  logic                               is_empty;
  logic                               is_full;

  modport source (output valid, status, value_out, count, is_empty, is_full, input ready);
  modport sink   (input valid, status, value_out, count, is_empty, is_full, output ready);
endinterface

@@ src/psl_ctrl.sv @@
module psl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output psl_pkg::psl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEND = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Handshake outputs follow the state directly.
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_SEND);
  assign cmd.exec  = (state == S_IDLE) && req_valid;

  // Take one item, hold its result until it is taken.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_SEND;
        end
      end
      S_SEND: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/psl_dp.sv @@
module psl_dp #(
  parameter int CAPACITY = psl_pkg::CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  psl_pkg::psl_cmd_t                   cmd,
  input  logic [psl_pkg::FUNC_W-1:0]          func,
  input  logic [psl_pkg::POS_W-1:0]           position,
  input  logic signed [psl_pkg::DATA_W-1:0]   value_in,
  output logic [psl_pkg::STATUS_W-1:0]        status,
  output logic signed [psl_pkg::DATA_W-1:0]   value_out,
  output logic [psl_pkg::COUNT_W-1:0]         count,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = (LW > psl_pkg::POS_W) ? LW : psl_pkg::POS_W;

  logic [LW-1:0]               length;
  logic [LW-1:0]               length_next;
  logic [psl_pkg::DATA_W-1:0]  cells [CAPACITY];
  logic [CW-1:0]               pos_cw;
  logic [CW-1:0]               len_cw;
  logic [CW-1:0]               len_next_cw;
  logic [AW-1:0]               rd_idx;
  logic [psl_pkg::DATA_W-1:0]  rd_data;
  logic                        val_pos;
  logic                        in_range;
  logic                        do_insert;
  logic                        do_delete;
  logic                        do_replace;
  logic [psl_pkg::STATUS_W-1:0] status_next;
  logic [psl_pkg::DATA_W-1:0]  vout_next;

  assign pos_cw   = CW'(position);
  assign len_cw   = CW'(length);
  assign rd_idx   = AW'(pos_cw);
  assign rd_data  = cells[rd_idx];
  assign val_pos  = !value_in[psl_pkg::DATA_W-1] && (value_in != '0);
  assign in_range = pos_cw < len_cw;

  // Decode the operation into status, read value and new length.
  always_comb begin
    status_next = psl_pkg::ST_OK;
    vout_next   = psl_pkg::NO_VALUE;
    length_next = length;
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    do_replace  = 1'b0;
    case (func)
      psl_pkg::FN_INSERT: begin
        if (!val_pos) begin
          status_next = psl_pkg::ST_BADVAL;
        end else if (pos_cw > len_cw) begin
          status_next = psl_pkg::ST_RANGE;
        end else if (len_cw >= CW'(CAPACITY)) begin
          status_next = psl_pkg::ST_FULL;
        end else begin
          do_insert   = 1'b1;
          length_next = length + LW'(1);
        end
      end
      psl_pkg::FN_DELETE: begin
        if (!in_range) begin
          status_next = psl_pkg::ST_RANGE;
        end else begin
          do_delete   = 1'b1;
          vout_next   = rd_data;
          length_next = length - LW'(1);
        end
      end
      psl_pkg::FN_GET: begin
        if (!in_range) begin
          status_next = psl_pkg::ST_RANGE;
        end else begin
          vout_next = rd_data;
        end
      end
      psl_pkg::FN_REPLACE: begin
        if (!val_pos) begin
          status_next = psl_pkg::ST_BADVAL;
        end else if (!in_range) begin
          status_next = psl_pkg::ST_RANGE;
        end else begin
          do_replace = 1'b1;
        end
      end
      psl_pkg::FN_CLEAR: begin
        length_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign len_next_cw = CW'(length_next);

  // Row of cells: each cell takes its lower or upper neighbour on a shift.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [psl_pkg::DATA_W-1:0] lower;
    logic [psl_pkg::DATA_W-1:0] upper;
    logic                       at_pos;
    logic                       above_pos;

    if (g == 0) begin : g_first
      assign lower = value_in;
    end else begin : g_mid
      assign lower = cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = cells[g];
    end else begin : g_body
      assign upper = cells[g+1];
    end

    assign at_pos    = (CW'(g) == pos_cw);
    assign above_pos = (CW'(g) > pos_cw);

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_insert && at_pos) begin
          cells[g] <= value_in;
        end else if (do_insert && above_pos) begin
          cells[g] <= lower;
        end else if (do_delete && (at_pos || above_pos)) begin
          cells[g] <= upper;
        end else if (do_replace && at_pos) begin
          cells[g] <= value_in;
        end
      end
    end
  end

  // List length.
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd.exec) begin
      length <= length_next;
    end
  end

  // Result register, held until the result is taken.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status    <= status_next;
      value_out <= vout_next;
      count     <= psl_pkg::COUNT_W'(len_next_cw);
      is_empty  <= (length_next == '0);
      is_full   <= (len_next_cw == CW'(CAPACITY));
    end
  end

endmodule

@@ src/positional_shift_list.sv @@
// Positional shift list: an ordered list of up to CAPACITY signed 32-bit
// entries kept packed from position 0, driven by insert, delete, get,
// replace and clear requests, each answered by one result with status,
// value, entry count and empty and full flags. The entries sit in a row
// of registers that all shift in the same cycle, so every operation
// executes with one update of the row; the result is then held in an
// output register until it is taken, and the next item is accepted the
// cycle after that. The block takes no new item while a result waits to
// be taken. Insert into a full list is refused; with a positive value and
// a position no greater than the count it gets the full status; no
// storage is added.
module positional_shift_list #(
  parameter int CAPACITY = psl_pkg::CAPACITY
) (
  input logic        clk,
  input logic        rst,
  psl_req_if.sink    req,
  psl_rsp_if.source  rsp
);

  psl_pkg::psl_cmd_t cmd;

  // Handshake sequencing.
  psl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Cell row, length and result register.
  psl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .func      (req.func),
    .position  (req.position),
    .value_in  (req.value_in),
    .status    (rsp.status),
    .value_out (rsp.value_out),
    .count     (rsp.count),
    .is_empty  (rsp.is_empty),
    .is_full   (rsp.is_full)
  );

endmodule
